### hw/rtl/sbsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_pkg
// Types, constants and codes shared by the serial bank-switch mapper files.
// ----------------------------------------------------------------------------
package sbsm_pkg;

    localparam logic [4:0]  SHIFT_MARK     = 5'h10;
    localparam logic [4:0]  CTRL_FIX_LAST  = 5'h0C;
    localparam logic [18:0] BANK16_BYTES   = 19'd16384;
    localparam logic [17:0] PATTERN_BYTES  = 18'd4096;

    localparam logic [4:0]  PRG_LOG2_MIN   = 5'd14;
    localparam logic [4:0]  PRG_LOG2_MAX   = 5'd18;
    localparam logic [4:0]  CHR_LOG2_MIN   = 5'd13;
    localparam logic [4:0]  CHR_LOG2_MAX   = 5'd17;

    localparam logic [4:0]  PRG_LOG2_RESET = 5'd18;
    localparam logic [4:0]  CHR_LOG2_RESET = 5'd13;

    localparam int          CFG_DATA_W     = 5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRG_SIZE_LOG2   = 2'd0,
        CFG_CHR_SIZE_LOG2   = 2'd1,
        CFG_HEADER_VERTICAL = 2'd2,
        CFG_UNUSED          = 2'd3
    } sbsm_cfg_idx_t;

    // Target of a completed serial load, from address bits 14:13
    typedef enum logic [1:0] {
        TGT_CONTROL = 2'd0,
        TGT_CHR0    = 2'd1,
        TGT_CHR1    = 2'd2,
        TGT_PRG     = 2'd3
    } sbsm_target_t;

    // PRG banking modes, control bits 3:2
    typedef enum logic [1:0] {
        PRG_32K_A     = 2'd0,
        PRG_32K_B     = 2'd1,
        PRG_FIX_FIRST = 2'd2,
        PRG_FIX_LAST  = 2'd3
    } sbsm_prg_mode_t;

    // Mirroring codes
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

    typedef struct packed {
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } sbsm_item_t;

    typedef struct packed {
        logic [17:0] prg_low_offset;
        logic [18:0] prg_high_offset;
        logic [16:0] chr_low_offset;
        logic [17:0] chr_high_offset;
        logic [1:0]  mirroring;
        logic        committed;
    } sbsm_result_t;

    typedef struct packed {
        logic [4:0] shift_value;
        logic [4:0] control_value;
        logic [4:0] chr_bank_zero;
        logic [4:0] chr_bank_one;
        logic [4:0] prg_bank_value;
    } sbsm_regs_t;

    typedef struct packed {
        logic [4:0] prg_size_log2;
        logic [4:0] chr_size_log2;
    } sbsm_cfg_t;

endpackage

### hw/rtl/serial_bank_switch_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_unit
// Serial-load bank-switch mapper: one result item per CPU write item.
// ----------------------------------------------------------------------------
// Path: item accept loads the input register, then the register update and
//   window decode load the result register, which raises result valid.
// Throughput: 1 item per cycle; stalls only while the result is not taken.
// Reset: async active low; clears valids, shift register to its marker,
//   control to fix-last mode with vertical mirroring, sizes to 256K / 8K.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [sbsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  sbsm_pkg::sbsm_item_t               item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output sbsm_pkg::sbsm_result_t             result
);

    sbsm_pkg::sbsm_item_t   item_reg;
    logic                   item_valid_reg;
    logic                   item_valid_next;
    sbsm_pkg::sbsm_result_t result_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    logic                   advance;
    logic                   accept;

    sbsm_pkg::sbsm_regs_t   regs_next;
    sbsm_pkg::sbsm_cfg_t    cfg;
    logic                   committed_next;
    sbsm_pkg::sbsm_result_t window;

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign accept     = item_valid && item_ready;

    sbsm_regs u_regs
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .step           (advance),
        .item           (item_reg),
        .regs_next      (regs_next),
        .committed_next (committed_next),
        .cfg            (cfg)
    );

    sbsm_window u_window
    (
        .regs      (regs_next),
        .cfg       (cfg),
        .committed (committed_next),
        .result    (window)
    );

    always_comb
    begin
        item_valid_next = accept ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        result_valid_next = advance ? 1'b1 :
                            (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= window;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### hw/rtl/sbsm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_regs
// Serial shift register, internal bank registers and size configuration.
// Produces the register set as it stands after the item being stepped.
// ----------------------------------------------------------------------------
module sbsm_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [sbsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               step,
    input  sbsm_pkg::sbsm_item_t               item,
    output sbsm_pkg::sbsm_regs_t               regs_next,
    output logic                               committed_next,
    output sbsm_pkg::sbsm_cfg_t                cfg
);

    sbsm_pkg::sbsm_regs_t  regs_reg;
    sbsm_pkg::sbsm_cfg_t   cfg_reg;
    sbsm_pkg::sbsm_cfg_t   cfg_next;
    sbsm_pkg::sbsm_regs_t  regs_store_next;
    logic [4:0]            shifted;
    sbsm_pkg::sbsm_target_t target;

    assign shifted = {item.write_data[0], regs_reg.shift_value[4:1]};
    assign target  = sbsm_pkg::sbsm_target_t'(item.cpu_address[14:13]);

    // Register set after this item
    always_comb
    begin
        regs_next      = regs_reg;
        committed_next = 1'b0;
        if (item.write_data[7])
        begin
            regs_next.shift_value   = sbsm_pkg::SHIFT_MARK;
            regs_next.control_value = regs_reg.control_value | sbsm_pkg::CTRL_FIX_LAST;
        end
        else if (!regs_reg.shift_value[0])
        begin
            regs_next.shift_value = shifted;
        end
        else
        begin
            // fifth bit: commit to the addressed register
            committed_next        = 1'b1;
            regs_next.shift_value = sbsm_pkg::SHIFT_MARK;
            unique case (target)
                sbsm_pkg::TGT_CONTROL: regs_next.control_value  = shifted;
                sbsm_pkg::TGT_CHR0:    regs_next.chr_bank_zero  = shifted;
                sbsm_pkg::TGT_CHR1:    regs_next.chr_bank_one   = shifted;
                sbsm_pkg::TGT_PRG:     regs_next.prg_bank_value = shifted;
                default:               regs_next.shift_value    = sbsm_pkg::SHIFT_MARK;
            endcase
        end
    end

    always_comb
    begin
        regs_store_next = regs_reg;
        cfg_next        = cfg_reg;
        if (step)
        begin
            regs_store_next = regs_next;
        end
        if (cfg_write)
        begin
            unique case (sbsm_pkg::sbsm_cfg_idx_t'(cfg_index))
                sbsm_pkg::CFG_PRG_SIZE_LOG2: cfg_next.prg_size_log2 = cfg_data;
                sbsm_pkg::CFG_CHR_SIZE_LOG2: cfg_next.chr_size_log2 = cfg_data;
                sbsm_pkg::CFG_HEADER_VERTICAL:
                begin
                    regs_store_next.control_value[1:0] = cfg_data[0] ?
                        sbsm_pkg::MIRROR_VERTICAL : sbsm_pkg::MIRROR_HORIZONTAL;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.shift_value    <= sbsm_pkg::SHIFT_MARK;
            regs_reg.control_value  <= sbsm_pkg::CTRL_FIX_LAST |
                                       {3'b000, sbsm_pkg::MIRROR_VERTICAL};
            regs_reg.chr_bank_zero  <= 5'd0;
            regs_reg.chr_bank_one   <= 5'd0;
            regs_reg.prg_bank_value <= 5'd0;
            cfg_reg.prg_size_log2   <= sbsm_pkg::PRG_LOG2_RESET;
            cfg_reg.chr_size_log2   <= sbsm_pkg::CHR_LOG2_RESET;
        end
        else
        begin
            regs_reg <= regs_store_next;
            cfg_reg  <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/sbsm_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_window
// Window offset decode: PRG and CHR byte offsets, masked by the ROM sizes,
// plus mirroring, from a register set.
// ----------------------------------------------------------------------------
module sbsm_window
(
    input  sbsm_pkg::sbsm_regs_t   regs,
    input  sbsm_pkg::sbsm_cfg_t    cfg,
    input  logic                   committed,
    output sbsm_pkg::sbsm_result_t result
);

    logic [4:0]  prg_log2;
    logic [4:0]  chr_log2;
    logic [18:0] prg_size;
    logic [18:0] prg_mask;
    logic [16:0] chr_mask;
    logic [17:0] prg_32k;
    logic [17:0] prg_16k;
    logic [16:0] chr_4k_lo;
    logic [16:0] chr_4k_hi;
    logic [16:0] chr_8k;
    logic [18:0] last_bank;
    sbsm_pkg::sbsm_prg_mode_t prg_mode;

    // Saturate sizes to the supported range
    always_comb
    begin
        priority if (cfg.prg_size_log2 < sbsm_pkg::PRG_LOG2_MIN)
            prg_log2 = sbsm_pkg::PRG_LOG2_MIN;
        else if (cfg.prg_size_log2 > sbsm_pkg::PRG_LOG2_MAX)
            prg_log2 = sbsm_pkg::PRG_LOG2_MAX;
        else
            prg_log2 = cfg.prg_size_log2;

        priority if (cfg.chr_size_log2 < sbsm_pkg::CHR_LOG2_MIN)
            chr_log2 = sbsm_pkg::CHR_LOG2_MIN;
        else if (cfg.chr_size_log2 > sbsm_pkg::CHR_LOG2_MAX)
            chr_log2 = sbsm_pkg::CHR_LOG2_MAX;
        else
            chr_log2 = cfg.chr_size_log2;
    end

    assign prg_size  = 19'd1 << prg_log2;
    assign prg_mask  = prg_size - 19'd1;
    assign chr_mask  = 17'((18'd1 << chr_log2) - 18'd1);
    assign last_bank = prg_size - sbsm_pkg::BANK16_BYTES;

    assign prg_32k   = {regs.prg_bank_value[3:1], 15'd0} & prg_mask[17:0];
    assign prg_16k   = {regs.prg_bank_value[3:0], 14'd0} & prg_mask[17:0];
    assign chr_4k_lo = {regs.chr_bank_zero, 12'd0} & chr_mask;
    assign chr_4k_hi = {regs.chr_bank_one, 12'd0} & chr_mask;
    assign chr_8k    = {regs.chr_bank_zero[4:1], 13'd0} & chr_mask;

    assign prg_mode  = sbsm_pkg::sbsm_prg_mode_t'(regs.control_value[3:2]);

    always_comb
    begin
        unique case (prg_mode)
            sbsm_pkg::PRG_FIX_FIRST:
            begin
                result.prg_low_offset  = 18'd0;
                result.prg_high_offset = {1'b0, prg_16k};
            end
            sbsm_pkg::PRG_FIX_LAST:
            begin
                result.prg_low_offset  = prg_16k;
                result.prg_high_offset = last_bank;
            end
            default:
            begin
                result.prg_low_offset  = prg_32k;
                result.prg_high_offset = {1'b0, prg_32k} + sbsm_pkg::BANK16_BYTES;
            end
        endcase

        if (regs.control_value[4])
        begin
            result.chr_low_offset  = chr_4k_lo;
            result.chr_high_offset = {1'b0, chr_4k_hi};
        end
        else
        begin
            result.chr_low_offset  = chr_8k;
            result.chr_high_offset = {1'b0, chr_8k} + sbsm_pkg::PATTERN_BYTES;
        end

        result.mirroring = regs.control_value[1:0];
        result.committed = committed;
    end

endmodule

### hw/rtl/sbsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_checker
// Port-level checks for the serial bank-switch mapper, bound to the top level.
// ----------------------------------------------------------------------------
module sbsm_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  logic                               item_ready,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  sbsm_pkg::sbsm_result_t             result
);

    // A stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Input side stalls only behind a waiting result
    a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("item_ready low without output backpressure");

    // A fresh result follows an accepted item through the input and result registers
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result appeared without an accepted item");

    // Offsets are always bank aligned
    a_offsets_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.prg_low_offset[13:0] == 14'd0 &&
                         result.prg_high_offset[13:0] == 14'd0 &&
                         result.chr_low_offset[11:0] == 12'd0 &&
                         result.chr_high_offset[11:0] == 12'd0)
        else $error("window offset not bank aligned");

endmodule

bind serial_bank_switch_mapper_unit sbsm_checker u_sbsm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

### verif/serial_bank_switch_mapper_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_unit_test
// Self-checking bench for the serial bank-switch mapper. A queue of CPU write
// items feeds a driver. The monitor predicts the bank windows of every
// accepted write and compares each result item field by field. The bench
// runs a short directed part, then random serial loads, reset writes and
// broken loads under several ROM size and mirroring settings, with
// out-of-range sizes among them.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_unit_test;

    import sbsm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 325;

    logic          clk;
    logic          rst_n;
    logic          cfg_write;
    logic [1:0]    cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic          item_valid;
    logic          item_ready;
    sbsm_item_t    item;
    logic          result_valid;
    logic          result_ready;
    sbsm_result_t  result;

    serial_bank_switch_mapper_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Mapper state as predicted by the bench
    logic [4:0] shift_reg;
    logic [4:0] control_reg;
    logic [4:0] chr_bank0_reg;
    logic [4:0] chr_bank1_reg;
    logic [4:0] prg_bank_reg;
    logic [4:0] prg_log2_reg;
    logic [4:0] chr_log2_reg;
    logic       header_vert_reg;

    sbsm_item_t   pending_writes[$];
    sbsm_result_t expected_windows[$];

    logic item_taken;
    logic idle_on;
    int   error_count;
    int   writes_sent;
    int   results_seen;
    int   loads_committed;
    int   stall_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [4:0] clamp_log2(logic [4:0] v, logic [4:0] lo, logic [4:0] hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic sbsm_result_t window_offsets(logic committed);
        sbsm_result_t   r;
        logic [31:0]    prg_size;
        logic [31:0]    prg_mask;
        logic [31:0]    chr_mask;
        logic [31:0]    lo_p;
        logic [31:0]    hi_p;
        logic [31:0]    lo_c;
        logic [31:0]    hi_c;
        sbsm_prg_mode_t mode;
        prg_size = 32'd1 << clamp_log2(prg_log2_reg, PRG_LOG2_MIN, PRG_LOG2_MAX);
        prg_mask = prg_size - 32'd1;
        chr_mask = (32'd1 << clamp_log2(chr_log2_reg, CHR_LOG2_MIN, CHR_LOG2_MAX)) - 32'd1;
        mode = sbsm_prg_mode_t'(control_reg[3:2]);
        case (mode)
            PRG_FIX_FIRST:
            begin
                lo_p = 32'd0;
                hi_p = (32'(prg_bank_reg[3:0]) << 14) & prg_mask;
            end
            PRG_FIX_LAST:
            begin
                lo_p = (32'(prg_bank_reg[3:0]) << 14) & prg_mask;
                hi_p = prg_size - 32'(BANK16_BYTES);
            end
            default:
            begin
                // 32K mode: the second window may run past a small ROM
                lo_p = (32'(prg_bank_reg[3:1]) << 15) & prg_mask;
                hi_p = lo_p + 32'(BANK16_BYTES);
            end
        endcase
        if (control_reg[4])
        begin
            lo_c = (32'(chr_bank0_reg) << 12) & chr_mask;
            hi_c = (32'(chr_bank1_reg) << 12) & chr_mask;
        end
        else
        begin
            // 8K mode: drop bit 0 of CHR bank 0, ignore CHR bank 1
            lo_c = (32'(chr_bank0_reg[4:1]) << 13) & chr_mask;
            hi_c = lo_c + 32'(PATTERN_BYTES);
        end
        r.prg_low_offset  = lo_p[17:0];
        r.prg_high_offset = hi_p[18:0];
        r.chr_low_offset  = lo_c[16:0];
        r.chr_high_offset = hi_c[17:0];
        r.mirroring       = control_reg[1:0];
        r.committed       = committed;
        return r;
    endfunction

    function automatic sbsm_result_t apply_cpu_write(sbsm_item_t w);
        logic       committed;
        logic [4:0] loaded;
        committed = 1'b0;
        loaded = {w.write_data[0], shift_reg[4:1]};
        if (w.write_data[7])
        begin
            shift_reg = SHIFT_MARK;
            control_reg = control_reg | CTRL_FIX_LAST;
        end
        else if (shift_reg[0])
        begin
            case (sbsm_target_t'(w.cpu_address[14:13]))
                TGT_CONTROL: control_reg   = loaded;
                TGT_CHR0:    chr_bank0_reg = loaded;
                TGT_CHR1:    chr_bank1_reg = loaded;
                default:     prg_bank_reg  = loaded;
            endcase
            shift_reg = SHIFT_MARK;
            committed = 1'b1;
        end
        else
        begin
            shift_reg = loaded;
        end
        return window_offsets(committed);
    endfunction

    function automatic logic [1:0] header_mirroring();
        return header_vert_reg ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic sbsm_item_t cpu_write(sbsm_target_t tgt, logic [7:0] data);
        sbsm_item_t w;
        w.cpu_address = 16'($urandom_range(0, 65535));
        w.cpu_address[14:13] = tgt;
        w.write_data = data;
        return w;
    endfunction

    // Shift in nbits bits of value, LSB first, with random filler in bits 6:1
    task automatic queue_shifts(sbsm_target_t tgt, logic [4:0] value, int nbits);
        logic [7:0] data;
        for (int i = 0; i < nbits; i++)
        begin
            data = {1'b0, 6'($urandom_range(0, 63)), value[i]};
            pending_writes.push_back(cpu_write(tgt, data));
        end
    endtask

    task automatic queue_reset_write(sbsm_target_t tgt);
        pending_writes.push_back(cpu_write(tgt, 8'h80 | 8'($urandom_range(0, 127))));
    endtask

    task automatic queue_random_phase(int count);
        int           start;
        int           pick;
        sbsm_target_t tgt;
        start = pending_writes.size();
        while (pending_writes.size() - start < count)
        begin
            pick = $urandom_range(0, 99);
            tgt = sbsm_target_t'($urandom_range(0, 3));
            if (pick < 70)
            begin
                queue_shifts(tgt, 5'($urandom_range(0, 31)), 5);
            end
            else if (pick < 82)
            begin
                // broken load: abort part way with a reset write
                queue_shifts(tgt, 5'($urandom_range(0, 31)), $urandom_range(1, 4));
                queue_reset_write(tgt);
            end
            else if (pick < 92)
            begin
                queue_reset_write(tgt);
            end
            else
            begin
                pending_writes.push_back(cpu_write(tgt, 8'($urandom_range(0, 255))));
            end
        end
    endtask

    // Hold until every queued item is accepted and every result is back
    task automatic wait_for_drain();
        while (pending_writes.size() != 0 || item_valid || expected_windows.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_register(sbsm_cfg_idx_t idx, logic [4:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PRG_SIZE_LOG2: prg_log2_reg = value;
            CFG_CHR_SIZE_LOG2: chr_log2_reg = value;
            CFG_HEADER_VERTICAL:
            begin
                header_vert_reg = value[0];
                control_reg = (control_reg & 5'h1C) | {3'b000, header_mirroring()};
            end
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [4:0] prg_log2, logic [4:0] chr_log2, logic vert);
        wait_for_drain();
        write_register(CFG_PRG_SIZE_LOG2, prg_log2);
        write_register(CFG_CHR_SIZE_LOG2, chr_log2);
        write_register(CFG_HEADER_VERTICAL, {4'($urandom_range(0, 15)), vert});
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $realtime, results_seen, field, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (pending_writes.size() != 0 &&
                    !(idle_on && $urandom_range(0, 99) < 15))
                begin
                    item       <= pending_writes.pop_front();
                    item_valid <= 1'b1;
                    writes_sent++;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
            result_ready <= !(idle_on && $urandom_range(0, 99) < 15);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on item accept, check on result accept
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sbsm_result_t want;
        item_taken = rst_n && item_valid && item_ready;
        if (rst_n)
        begin
            if (item_taken)
                expected_windows.push_back(apply_cpu_write(item));
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_windows.size() == 0)
                begin
                    error_count++;
                    $display("[%0t] result with no write waiting", $realtime);
                end
                else
                begin
                    want = expected_windows.pop_front();
                    if (result.committed)
                        loads_committed++;
                    if (result.prg_low_offset !== want.prg_low_offset)
                        report_mismatch("prg_low_offset", result.prg_low_offset,
                                        want.prg_low_offset);
                    if (result.prg_high_offset !== want.prg_high_offset)
                        report_mismatch("prg_high_offset", result.prg_high_offset,
                                        want.prg_high_offset);
                    if (result.chr_low_offset !== want.chr_low_offset)
                        report_mismatch("chr_low_offset", result.chr_low_offset,
                                        want.chr_low_offset);
                    if (result.chr_high_offset !== want.chr_high_offset)
                        report_mismatch("chr_high_offset", result.chr_high_offset,
                                        want.chr_high_offset);
                    if (result.mirroring !== want.mirroring)
                        report_mismatch("mirroring", result.mirroring, want.mirroring);
                    if (result.committed !== want.committed)
                        report_mismatch("committed", result.committed, want.committed);
                end
            end
            if (item_taken || (result_valid && result_ready))
                stall_cycles = 0;
            else if (pending_writes.size() != 0 || item_valid || expected_windows.size() != 0)
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("** serial_bank_switch_mapper_unit: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_PRG_SIZE_LOG2;
        cfg_data        = '0;
        item_valid      = 1'b0;
        item            = '0;
        result_ready    = 1'b0;
        item_taken      = 1'b0;
        idle_on         = 1'b1;
        error_count     = 0;
        writes_sent     = 0;
        results_seen    = 0;
        loads_committed = 0;
        stall_cycles    = 0;

        prg_log2_reg    = PRG_LOG2_RESET;
        chr_log2_reg    = CHR_LOG2_RESET;
        header_vert_reg = 1'b1;
        shift_reg       = SHIFT_MARK;
        control_reg     = CTRL_FIX_LAST | {3'b000, header_mirroring()};
        chr_bank0_reg   = '0;
        chr_bank1_reg   = '0;
        prg_bank_reg    = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every target, reset writes, aborted load
        pending_writes.push_back('{cpu_address: 16'hFFFF, write_data: 8'hFF});
        pending_writes.push_back('{cpu_address: 16'h0000, write_data: 8'h00});
        pending_writes.push_back('{cpu_address: 16'h0000, write_data: 8'h80});
        queue_shifts(TGT_PRG, 5'h1F, 5);
        queue_shifts(TGT_CHR0, 5'h1F, 5);
        queue_shifts(TGT_CHR1, 5'h15, 5);
        queue_shifts(TGT_CONTROL, 5'h12, 2);
        queue_reset_write(TGT_CONTROL);
        queue_shifts(TGT_CONTROL, 5'h10, 5);

        // Random phases, each under its own sizes and mirroring
        apply_setting(5'd14, 5'd13, 1'b0);
        write_register(CFG_UNUSED, 5'($urandom_range(0, 31)));
        @(negedge clk);
        cfg_write <= 1'b0;
        queue_random_phase(PHASE_ITEMS);

        apply_setting(PRG_LOG2_MAX, CHR_LOG2_MAX, 1'b1);
        queue_random_phase(PHASE_ITEMS);

        // Stretch with no idling on either side
        apply_setting(5'd16, 5'd15, 1'b0);
        idle_on = 1'b0;
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();
        idle_on = 1'b1;

        // Out-of-range sizes saturate
        apply_setting(5'd0, 5'd31, 1'b1);
        queue_random_phase(PHASE_ITEMS);

        apply_setting(5'd31, 5'd0, 1'b0);
        queue_random_phase(PHASE_ITEMS);

        apply_setting(5'd15, 5'd14, 1'b1);
        queue_random_phase(PHASE_ITEMS);

        wait_for_drain();
        repeat (5) @(posedge clk);

        $display("Covered %0d CPU write items (%0d completed loads) over six size and",
                 writes_sent, loads_committed);
        $display("mirroring settings; %0d result items checked, %0d mismatches.",
                 results_seen, error_count);
        if (error_count == 0)
            $display("** serial_bank_switch_mapper_unit: PASSED **");
        else
            $display("** serial_bank_switch_mapper_unit: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sbsm_pkg.sv
hw/rtl/sbsm_regs.sv
hw/rtl/sbsm_window.sv
hw/rtl/serial_bank_switch_mapper_unit.sv
hw/rtl/sbsm_checker.sv
verif/serial_bank_switch_mapper_unit_test.sv
